// ===== src/aligned_damping_force_top_assert.svh =====
// Assertion macros shared by the damping force block.
`ifndef ALIGNED_DAMPING_FORCE_TOP_ASSERT_SVH
`define ALIGNED_DAMPING_FORCE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADF_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("damping force check failed");

// Next-cycle implication, checked outside reset.
`define ADF_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("damping force check failed");

`endif

// ===== src/adf_pkg.sv =====
// Types and constants of the aligned damping force block.
package adf_pkg;

  localparam int MAG_W     = 62;
  localparam int NORM_LAT  = 73;
  localparam int POST_LAT  = 12;

  localparam logic [31:0] GAIN_RESET = 32'd6553600;

  typedef enum logic [0:0] {
    REG_DAMPING_MAIN,
    REG_DAMPING_CROSS
  } cfg_reg_t;

  typedef logic signed [31:0] q16_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [2:0][31:0] unit3_t;

  typedef struct packed {
    q16_t meas_vel_x;
    q16_t meas_vel_y;
    q16_t meas_vel_z;
    q16_t target_vel_x;
    q16_t target_vel_y;
    q16_t target_vel_z;
    q16_t dir_a_x;
    q16_t dir_a_y;
    q16_t dir_a_z;
    q16_t dir_b_x;
    q16_t dir_b_y;
    q16_t dir_b_z;
  } vel_item_t;

  typedef struct packed {
    q16_t force_x;
    q16_t force_y;
    q16_t force_z;
    logic identity_fallback;
  } frc_item_t;

  // Sign and magnitude of one vector on its way into the normalizer.
  typedef struct packed {
    logic [2:0] neg;
    mag_t [2:0] mag;
  } norm_in_t;

endpackage

// ===== src/adf_vel_if.sv =====
// Request channel carrying one velocity and direction sample.
interface adf_vel_if import adf_pkg::*; ();
  logic      valid;
  logic      ready;
  vel_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/adf_frc_if.sv =====
// Request channel carrying one damping force result.
interface adf_frc_if import adf_pkg::*; ();
  logic      valid;
  logic      ready;
  frc_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/adf_norm.sv =====
// Pipelined vector normalizer: prescale, integer square root, long division.
module adf_norm import adf_pkg::*; (
  input  logic     clk,
  input  logic     adv,
  input  norm_in_t src,
  output unit3_t   u
);

  localparam int SHIFT_STEPS = 5;
  localparam int S_SQUARE    = SHIFT_STEPS + 1;
  localparam int S_SUM       = S_SQUARE + 1;
  localparam int S_SQRT0     = S_SUM + 1;
  localparam int S_DIVPREP   = S_SQRT0 + 32;
  localparam int S_DIV0      = S_DIVPREP + 1;
  localparam int S_OUT       = S_DIV0 + 31;

  localparam mag_t SHIFT_LIM = mag_t'(1) << 31;

  typedef struct packed {
    logic [2:0]       neg;
    mag_t [2:0]       m;
    mag_t             mx;
    logic [63:0]      n;
    logic [63:0]      res;
    logic [2:0][63:0] rem;
    logic [31:0]      r;
    logic [2:0][30:0] q;
    logic             zero;
    unit3_t           u;
  } ns_t;

  ns_t st  [NORM_LAT];
  ns_t nxt [NORM_LAT];

  function automatic ns_t f_load(input norm_in_t x);
    ns_t o;
    o     = '0;
    o.neg = x.neg;
    o.m   = x.mag;
    o.mx  = x.mag[0];
    if (x.mag[1] > o.mx) o.mx = x.mag[1];
    if (x.mag[2] > o.mx) o.mx = x.mag[2];
    return o;
  endfunction

  // Halving all magnitudes together until the largest is at most 2^31 is a
  // binary search over the shift count.
  function automatic ns_t f_shift(input ns_t p, input int step);
    ns_t o;
    o = p;
    if ((p.mx >> (step - 1)) > SHIFT_LIM) begin
      o.mx = p.mx >> step;
      for (int i = 0; i < 3; i++) o.m[i] = p.m[i] >> step;
    end
    return o;
  endfunction

  function automatic ns_t f_square(input ns_t p);
    ns_t o;
    o = p;
    for (int i = 0; i < 3; i++) o.rem[i] = p.m[i][31:0] * p.m[i][31:0];
    return o;
  endfunction

  function automatic ns_t f_sum(input ns_t p);
    ns_t o;
    o      = p;
    o.n    = p.rem[0] + p.rem[1] + p.rem[2];
    o.res  = '0;
    o.zero = (o.n == '0);
    return o;
  endfunction

  function automatic ns_t f_sqrt(input ns_t p, input int j);
    ns_t         o;
    logic [63:0] b;
    logic [63:0] t;
    o = p;
    b = 64'(1) << (62 - 2 * j);
    t = p.res + b;
    if (p.n >= t) begin
      o.n   = p.n - t;
      o.res = (p.res >> 1) + b;
    end else begin
      o.res = p.res >> 1;
    end
    return o;
  endfunction

  function automatic ns_t f_divprep(input ns_t p);
    ns_t o;
    o   = p;
    o.r = p.res[31:0];
    o.q = '0;
    for (int i = 0; i < 3; i++) begin
      o.rem[i] = (64'(p.m[i]) << 30) + 64'(p.res[31:0] >> 1);
    end
    return o;
  endfunction

  function automatic ns_t f_div(input ns_t p, input int k);
    ns_t         o;
    logic [63:0] d;
    o = p;
    d = 64'(p.r) << k;
    for (int i = 0; i < 3; i++) begin
      if (p.rem[i] >= d) begin
        o.rem[i]  = p.rem[i] - d;
        o.q[i][k] = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic ns_t f_out(input ns_t p);
    ns_t         o;
    logic [31:0] qq;
    o = p;
    for (int i = 0; i < 3; i++) begin
      qq = {1'b0, p.q[i]};
      if (p.zero) o.u[i] = '0;
      else        o.u[i] = p.neg[i] ? -qq : qq;
    end
    return o;
  endfunction

  for (genvar s = 0; s < NORM_LAT; s++) begin : g_st
    if (s == 0) begin : g_load
      assign nxt[s] = f_load(src);
    end else if (s <= SHIFT_STEPS) begin : g_shift
      assign nxt[s] = f_shift(st[s-1], 16 >> (s - 1));
    end else if (s == S_SQUARE) begin : g_square
      assign nxt[s] = f_square(st[s-1]);
    end else if (s == S_SUM) begin : g_sum
      assign nxt[s] = f_sum(st[s-1]);
    end else if (s < S_DIVPREP) begin : g_sqrt
      assign nxt[s] = f_sqrt(st[s-1], s - S_SQRT0);
    end else if (s == S_DIVPREP) begin : g_divprep
      assign nxt[s] = f_divprep(st[s-1]);
    end else if (s < S_OUT) begin : g_div
      assign nxt[s] = f_div(st[s-1], S_OUT - 1 - s);
    end else begin : g_out
      assign nxt[s] = f_out(st[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NORM_LAT; s++) st[s] <= nxt[s];
    end
  end

  assign u = st[NORM_LAT-1].u;

endmodule

// ===== src/aligned_damping_force_top.sv =====
// Top level of the aligned damping force block.
//
// The vel channel takes one sample per request: measured and target velocity
// and two direction vectors, all signed Q16.16. The frc channel returns one
// result per sample, in order: the saturated force and the fallback flag.
// The two gains are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
// A write of zero leaves the gain unchanged. The datapath is one register
// pipeline: an input stage, the normalizer of both directions (73 stages:
// prescale, 32-step square root, 31-step divide), two cross product stages,
// the normalizer of the cross product, and 12 stages of projection, gain and
// back projection. One sample enters every cycle unless frc is stalled; then
// the whole pipeline holds and vel.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets both gains to
// 100.0; no result is pending after reset.
`include "aligned_damping_force_top_assert.svh"

module aligned_damping_force_top import adf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  adf_vel_if.sink     vel,
  adf_frc_if.source   frc,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef struct packed {
    logic             fb;
    logic [2:0][32:0] e;
  } sb1_t;

  typedef struct packed {
    logic             fb;
    logic [2:0][32:0] e;
    unit3_t           ua;
    unit3_t           ub;
  } sb2_t;

  typedef struct packed {
    logic             fb;
    logic [2:0][32:0] e;
    unit3_t [2:0]     col;
  } sbp_t;

  function automatic norm_in_t load32(input q16_t x0, input q16_t x1, input q16_t x2);
    norm_in_t    o;
    logic [31:0] v [3];
    v[0] = x0;
    v[1] = x1;
    v[2] = x2;
    for (int i = 0; i < 3; i++) begin
      o.neg[i] = v[i][31];
      o.mag[i] = MAG_W'(v[i][31] ? 32'(-v[i]) : v[i]);
    end
    return o;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647)       return 32'h7fffffff;
    else if (x < -64'sd2147483648) return 32'h80000000;
    else                           return x[31:0];
  endfunction

  logic        adv;
  logic [31:0] dmain;
  logic [31:0] dcross;

  assign adv       = !frc.valid || frc.ready;
  assign vel.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dmain  <= GAIN_RESET;
      dcross <= GAIN_RESET;
    end else if (cfg_we && cfg_data != '0) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DAMPING_MAIN:  dmain  <= cfg_data;
        REG_DAMPING_CROSS: dcross <= cfg_data;
      endcase
    end
  end

  // Input stage: velocity error, fallback decision, direction magnitudes.
  logic     t0_v;
  sb1_t     t0_sb;
  norm_in_t t0_a;
  norm_in_t t0_b;

  always_ff @(posedge clk) begin
    if (rst) t0_v <= 1'b0;
    else if (adv) t0_v <= vel.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_sb.e[0] <= $signed({vel.data.target_vel_x[31], vel.data.target_vel_x})
                  - $signed({vel.data.meas_vel_x[31], vel.data.meas_vel_x});
      t0_sb.e[1] <= $signed({vel.data.target_vel_y[31], vel.data.target_vel_y})
                  - $signed({vel.data.meas_vel_y[31], vel.data.meas_vel_y});
      t0_sb.e[2] <= $signed({vel.data.target_vel_z[31], vel.data.target_vel_z})
                  - $signed({vel.data.meas_vel_z[31], vel.data.meas_vel_z});
      t0_sb.fb   <= (vel.data.target_vel_x == '0 && vel.data.target_vel_y == '0
                     && vel.data.target_vel_z == '0)
                 || (vel.data.dir_b_x == '0 && vel.data.dir_b_y == '0
                     && vel.data.dir_b_z == '0);
      t0_a <= load32(vel.data.dir_a_x, vel.data.dir_a_y, vel.data.dir_a_z);
      t0_b <= load32(vel.data.dir_b_x, vel.data.dir_b_y, vel.data.dir_b_z);
    end
  end

  // Both directions are normalized side by side.
  unit3_t ua;
  unit3_t ub;
  logic   v1 [NORM_LAT];
  sb1_t   d1 [NORM_LAT];

  adf_norm u_norm_a (.clk(clk), .adv(adv), .src(t0_a), .u(ua));
  adf_norm u_norm_b (.clk(clk), .adv(adv), .src(t0_b), .u(ub));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NORM_LAT; j++) v1[j] <= 1'b0;
    end else if (adv) begin
      v1[0] <= t0_v;
      for (int j = 1; j < NORM_LAT; j++) v1[j] <= v1[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0] <= t0_sb;
      for (int j = 1; j < NORM_LAT; j++) d1[j] <= d1[j-1];
    end
  end

  // Cross product of the two unit vectors, exact in Q4.60.
  logic               x1_v;
  logic signed [63:0] x1_p [6];
  sb2_t               x1_sb;
  logic               x2_v;
  logic signed [63:0] x2_c [3];
  sb2_t               x2_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
      x2_v <= 1'b0;
    end else if (adv) begin
      x1_v <= v1[NORM_LAT-1];
      x2_v <= x1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_p[0]  <= $signed(ua[1]) * $signed(ub[2]);
      x1_p[1]  <= $signed(ua[2]) * $signed(ub[1]);
      x1_p[2]  <= $signed(ua[2]) * $signed(ub[0]);
      x1_p[3]  <= $signed(ua[0]) * $signed(ub[2]);
      x1_p[4]  <= $signed(ua[0]) * $signed(ub[1]);
      x1_p[5]  <= $signed(ua[1]) * $signed(ub[0]);
      x1_sb.fb <= d1[NORM_LAT-1].fb;
      x1_sb.e  <= d1[NORM_LAT-1].e;
      x1_sb.ua <= ua;
      x1_sb.ub <= ub;
      x2_c[0]  <= x1_p[0] - x1_p[1];
      x2_c[1]  <= x1_p[2] - x1_p[3];
      x2_c[2]  <= x1_p[4] - x1_p[5];
      x2_sb    <= x1_sb;
    end
  end

  norm_in_t nc_in;
  unit3_t   uc;
  logic     v2 [NORM_LAT];
  sb2_t     d2 [NORM_LAT];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nc_in.neg[i] = x2_c[i][63];
      nc_in.mag[i] = MAG_W'(x2_c[i][63] ? -x2_c[i] : x2_c[i]);
    end
  end

  adf_norm u_norm_c (.clk(clk), .adv(adv), .src(nc_in), .u(uc));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NORM_LAT; j++) v2[j] <= 1'b0;
    end else if (adv) begin
      v2[0] <= x2_v;
      for (int j = 1; j < NORM_LAT; j++) v2[j] <= v2[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2[0] <= x2_sb;
      for (int j = 1; j < NORM_LAT; j++) d2[j] <= d2[j-1];
    end
  end

  // Projection onto the basis, gain, and back projection.
  unit3_t [2:0] cols;
  logic         vp [POST_LAT];
  sbp_t         sp [POST_LAT-1];

  assign cols = {uc, d2[NORM_LAT-1].ub, d2[NORM_LAT-1].ua};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < POST_LAT; j++) vp[j] <= 1'b0;
    end else if (adv) begin
      vp[0] <= v2[NORM_LAT-1];
      for (int j = 1; j < POST_LAT; j++) vp[j] <= vp[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp[0].fb  <= d2[NORM_LAT-1].fb;
      sp[0].e   <= d2[NORM_LAT-1].e;
      sp[0].col <= cols;
      for (int j = 1; j < POST_LAT - 1; j++) sp[j] <= sp[j-1];
    end
  end

  logic signed [64:0] pe  [3][3];
  logic [64:0]        pm  [3][3];
  logic               ps  [3][3];
  logic [33:0]        pr  [3][3];
  logic               ps3 [3][3];
  logic signed [35:0] w   [3];
  logic [34:0]        wm  [3];
  logic               ws  [3];
  logic [66:0]        gp  [3];
  logic               gs6 [3];
  logic [50:0]        gm  [3];
  logic               gs7 [3];
  logic [30:0]        colm [3][3];
  logic               cs  [3][3];
  logic [55:0]        lo  [3][3];
  logic [56:0]        hi  [3][3];
  logic               sg8 [3][3];
  logic [81:0]        full [3][3];
  logic               sg9 [3][3];
  logic [51:0]        rt  [3][3];
  logic               sg10 [3][3];
  logic signed [54:0] f   [3];
  frc_item_t          out_data;

  always_ff @(posedge clk) begin
    logic signed [35:0] acc;
    logic signed [54:0] facc;
    logic [31:0]        c;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pe[k][i]  <= $signed(cols[k][i]) * $signed(d2[NORM_LAT-1].e[i]);
          pm[k][i]  <= pe[k][i][64] ? 65'(-pe[k][i]) : 65'(pe[k][i]);
          ps[k][i]  <= pe[k][i][64];
          pr[k][i]  <= 34'((pm[k][i] + (65'(1) << 29)) >> 30);
          ps3[k][i] <= ps[k][i];
        end
        acc = '0;
        for (int i = 0; i < 3; i++) begin
          if (ps3[k][i]) acc = acc - $signed({2'b00, pr[k][i]});
          else           acc = acc + $signed({2'b00, pr[k][i]});
        end
        w[k]   <= acc;
        wm[k]  <= w[k][35] ? 35'(-w[k]) : 35'(w[k]);
        ws[k]  <= w[k][35];
        gp[k]  <= ((k == 0) ? 67'(dmain) : 67'(dcross)) * 67'(wm[k]);
        gs6[k] <= ws[k];
        gm[k]  <= 51'((gp[k] + (67'(1) << 15)) >> 16);
        gs7[k] <= gs6[k];
        for (int i = 0; i < 3; i++) begin
          c           = sp[5].col[k][i];
          colm[k][i] <= c[31] ? 31'(-c) : c[30:0];
          cs[k][i]   <= c[31];
          // The gain times a column entry is split in two partial products.
          lo[k][i]   <= gm[k][24:0] * colm[k][i];
          hi[k][i]   <= gm[k][50:25] * colm[k][i];
          sg8[k][i]  <= gs7[k] ^ cs[k][i];
          full[k][i] <= (82'(hi[k][i]) << 25) + 82'(lo[k][i]);
          sg9[k][i]  <= sg8[k][i];
          rt[k][i]   <= 52'((full[k][i] + (82'(1) << 29)) >> 30);
          sg10[k][i] <= sg9[k][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        facc = '0;
        for (int k = 0; k < 3; k++) begin
          if (sg10[k][i]) facc = facc - $signed({3'b000, rt[k][i]});
          else            facc = facc + $signed({3'b000, rt[k][i]});
        end
        f[i] <= facc;
      end
      if (sp[10].fb) begin
        out_data.force_x <= sat32(64'($signed(sp[10].e[0])));
        out_data.force_y <= sat32(64'($signed(sp[10].e[1])));
        out_data.force_z <= sat32(64'($signed(sp[10].e[2])));
      end else begin
        out_data.force_x <= sat32(64'(f[0]));
        out_data.force_y <= sat32(64'(f[1]));
        out_data.force_z <= sat32(64'(f[2]));
      end
      out_data.identity_fallback <= sp[10].fb;
    end
  end

  assign frc.valid = vp[POST_LAT-1];
  assign frc.data  = out_data;

  `ADF_CHECK(a_stall_blocks_input, frc.valid && !frc.ready, !vel.ready)
  `ADF_CHECK_NEXT(a_accept_enters, vel.valid && vel.ready, t0_v)
  `ADF_CHECK(a_gains_nonzero, 1'b1, dmain != '0 && dcross != '0)

endmodule
